[sv/ec2d_pkg.sv]
package ec2d_pkg;

  // widths of the datapath
  localparam int DDW = 66;        // separation squared
  localparam int PMW = 66;        // magnitude of the projection product
  localparam int PRW = 98;        // |p| * |d| per axis
  localparam int NW  = 114;       // divider numerator
  localparam int DW  = 66;        // divider denominator and remainder
  localparam int QW  = 50;        // divider quotient bits
  localparam int VDW = 36;        // velocity change magnitude
  localparam int SW  = 72;        // radicand of the impulse root
  localparam int RW  = SW / 2;    // root bits
  localparam int RMW = RW + 2;    // root remainder

  localparam logic signed [37:0] SAT_MAX = 38'sd2147483647;
  localparam logic signed [37:0] SAT_MIN = -38'sd2147483648;

  typedef struct packed {
    logic [31:0] vax;
    logic [31:0] vay;
    logic [31:0] vbx;
    logic [31:0] vby;
    logic [31:0] ma;
    logic [31:0] mb;
    logic        deg;
    logic        nx;
    logic        ny;
  } side_t;

  // one restoring step: {quotient bit, new remainder}
  function automatic logic [DW:0] div_step(input logic [DW-1:0] rem, input logic nb,
                                           input logic [DW-1:0] den);
    logic [DW:0] t;
    t = {rem, nb};
    if (t >= {1'b0, den}) begin
      t = t - {1'b0, den};
      return {1'b1, t[DW-1:0]};
    end
    return {1'b0, t[DW-1:0]};
  endfunction

  // one digit of the integer square root: {root bit, new remainder}
  function automatic logic [RMW:0] sqrt_step(input logic [RMW-1:0] rem,
                                             input logic [RW-1:0] root,
                                             input logic [1:0] pair);
    logic [RMW+1:0] t;
    logic [RMW+1:0] trial;
    t     = {rem, pair};
    trial = {2'b00, root, 2'b01};
    if (t >= trial) begin
      t = t - trial;
      return {1'b1, t[RMW-1:0]};
    end
    return {1'b0, t[RMW-1:0]};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [37:0] v);
    if (v > SAT_MAX) begin
      return 32'h7fff_ffff;
    end
    if (v < SAT_MIN) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

[sv/ec2d_div.sv]
module ec2d_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic [ec2d_pkg::NW-1:0]   num_i,
  input  logic [ec2d_pkg::DW-1:0]   den_i,
  output logic                      vld_o,
  output logic [ec2d_pkg::QW-1:0]   quo_o
);

  localparam int NW = ec2d_pkg::NW;
  localparam int DW = ec2d_pkg::DW;
  localparam int QW = ec2d_pkg::QW;

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] nlo_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [QW-1:0] vld_q;
  logic [DW:0]   stp   [QW];
  logic [DW-1:0] rem0;

  // quotient is known to fit QW bits, so the top of the numerator starts below den
  assign rem0 = {{(DW-NW+QW){1'b0}}, num_i[NW-1:QW]};

  always_comb begin
    stp[0] = ec2d_pkg::div_step(rem0, num_i[QW-1], den_i);
    for (int k = 1; k < QW; k++) begin
      stp[k] = ec2d_pkg::div_step(rem_q[k-1], nlo_q[k-1][QW-1], den_q[k-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= stp[0][DW-1:0];
    den_q[0] <= den_i;
    nlo_q[0] <= {num_i[QW-2:0], 1'b0};
    quo_q[0] <= {{(QW-1){1'b0}}, stp[0][DW]};
    for (int k = 1; k < QW; k++) begin
      rem_q[k] <= stp[k][DW-1:0];
      den_q[k] <= den_q[k-1];
      nlo_q[k] <= {nlo_q[k-1][QW-2:0], 1'b0};
      quo_q[k] <= {quo_q[k-1][QW-2:0], stp[k][DW]};
    end
  end

  assign vld_o = vld_q[QW-1];
  assign quo_o = quo_q[QW-1];

endmodule

[sv/ec2d_sqrt.sv]
module ec2d_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic [ec2d_pkg::SW-1:0]   rad_i,
  output logic                      vld_o,
  output logic [ec2d_pkg::RW-1:0]   root_o
);

  localparam int SW  = ec2d_pkg::SW;
  localparam int RW  = ec2d_pkg::RW;
  localparam int RMW = ec2d_pkg::RMW;

  logic [RMW-1:0] rem_q  [RW];
  logic [RW-1:0]  root_q [RW];
  logic [SW-1:0]  rad_q  [RW];
  logic [RW-1:0]  vld_q;
  logic [RMW:0]   stp    [RW];

  always_comb begin
    stp[0] = ec2d_pkg::sqrt_step('0, '0, rad_i[SW-1:SW-2]);
    for (int k = 1; k < RW; k++) begin
      stp[k] = ec2d_pkg::sqrt_step(rem_q[k-1], root_q[k-1], rad_q[k-1][SW-1:SW-2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[RW-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= stp[0][RMW-1:0];
    root_q[0] <= {{(RW-1){1'b0}}, stp[0][RMW]};
    rad_q[0]  <= {rad_i[SW-3:0], 2'b00};
    for (int k = 1; k < RW; k++) begin
      rem_q[k]  <= stp[k][RMW-1:0];
      root_q[k] <= {root_q[k-1][RW-2:0], stp[k][RMW]};
      rad_q[k]  <= {rad_q[k-1][SW-3:0], 2'b00};
    end
  end

  assign vld_o  = vld_q[RW-1];
  assign root_o = root_q[RW-1];

endmodule

[sv/elastic_collision_2d_update.sv]
// Two-body elastic collision update along the line of centres, Q16.16 fixed point.
// Input: drive both bodies (position, velocity, mass) and pulse start_i; a transfer
// happens at each edge with start_i high and busy_o low. busy_o is always low, so a
// new pair may enter on every cycle.
// Output: done_o is high for exactly one cycle with the new velocities, the magnitude
// of the second body's momentum change and the degenerate flag; the receiver must
// take it in that cycle.
// The path from transfer to done_o runs through 7 setup stages, two 50-stage dividers
// for the projection, 2 stages, four 50-stage dividers for the mass ratio, 2 stages,
// a 36-stage square root for the impulse and 2 final stages. Throughput is one pair
// per cycle; the one-quotient-bit-per-stage dividers set the depth.
// Zero separation or zero mass sum passes the velocities through, gives zero impulse
// and raises degenerate.
// Reset clears all valid bits, so nothing is emitted until new pairs arrive.
module elastic_collision_2d_update (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_a_x_i,
  input  logic signed [31:0] pos_a_y_i,
  input  logic signed [31:0] vel_a_x_i,
  input  logic signed [31:0] vel_a_y_i,
  input  logic        [31:0] mass_a_i,
  input  logic signed [31:0] pos_b_x_i,
  input  logic signed [31:0] pos_b_y_i,
  input  logic signed [31:0] vel_b_x_i,
  input  logic signed [31:0] vel_b_y_i,
  input  logic        [31:0] mass_b_i,
  output logic               done_o,
  output logic signed [31:0] new_vel_a_x_o,
  output logic signed [31:0] new_vel_a_y_o,
  output logic signed [31:0] new_vel_b_x_o,
  output logic signed [31:0] new_vel_b_y_o,
  output logic        [31:0] impulse_size_o,
  output logic               degenerate_o
);

  localparam int DDW = ec2d_pkg::DDW;
  localparam int PMW = ec2d_pkg::PMW;
  localparam int PRW = ec2d_pkg::PRW;
  localparam int NW  = ec2d_pkg::NW;
  localparam int DW  = ec2d_pkg::DW;
  localparam int QW  = ec2d_pkg::QW;
  localparam int VDW = ec2d_pkg::VDW;
  localparam int SW  = ec2d_pkg::SW;
  localparam int RW  = ec2d_pkg::RW;

  // valid chain
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v9_q, v10_q, v11_q, v12_q, v13_q;
  logic v8, v10in, v12;

  ec2d_pkg::side_t s1_q, s2_q, s3_q, s4_q, s5_q, s6_q, s7_q, s9_q, s10_q, s11_q, s13_q;
  ec2d_pkg::side_t side12_q;
  ec2d_pkg::side_t s2_d, s4_d, s11_d;
  ec2d_pkg::side_t sd1_q [QW];
  ec2d_pkg::side_t sd2_q [QW];
  ec2d_pkg::side_t sd3_q [RW];

  // stage 1
  logic signed [32:0] d1x_q, d1y_q, w1x_q, w1y_q;
  // stage 2
  logic signed [65:0] sq2x_q, sq2y_q, pw2x_q, pw2y_q;
  logic [31:0]        ad2x_q, ad2y_q;
  logic signed [32:0] abx, aby;
  // stage 3
  logic [DDW-1:0]     dd3_q;
  logic signed [66:0] p3_q;
  logic [31:0]        ad3x_q, ad3y_q;
  // stage 4
  logic [DDW-1:0]     dd4_q;
  logic [PMW-1:0]     pm4_q;
  logic [31:0]        ad4x_q, ad4y_q;
  logic signed [66:0] pneg_val;
  // stage 5
  logic [DDW-1:0]     dd5_q;
  logic [65:0]        pl5x_q, pl5y_q;
  logic [63:0]        ph5x_q, ph5y_q;
  // stage 6
  logic [DDW-1:0]     dd6_q;
  logic [PRW-1:0]     pr6x_q, pr6y_q;
  // stage 7
  logic [NW-1:0]      n7x_q, n7y_q;
  logic [DW-1:0]      dd7_q;
  // first divider
  logic [QW-1:0]      q8x, q8y;
  // stage 9
  logic [57:0]        al9x_q, ah9x_q, al9y_q, ah9y_q, bl9x_q, bh9x_q, bl9y_q, bh9y_q;
  logic [32:0]        m9_q;
  logic [32:0]        m2a, m2b;
  // stage 10
  logic [NW-1:0]      na10x_q, na10y_q, nb10x_q, nb10y_q;
  logic [DW-1:0]      den10_q;
  logic [NW-1:0]      mround;
  // second divider
  logic [QW-1:0]      dax, day, dbx, dby;
  // stage 11
  logic [SW-1:0]      sq11x_q, sq11y_q;
  logic signed [37:0] nvax, nvay, nvbx, nvby;
  // stage 12
  logic [SW-1:0]      s12_q;
  // square root
  logic [RW-1:0]      root;
  // stage 13
  logic [67:0]        pr13_q;
  // output
  logic [67:0]        imp_sum;
  logic [51:0]        imp_w;
  logic               done_q, deg_q;
  logic [31:0]        nvax_q, nvay_q, nvbx_q, nvby_q, imp_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v9_q <= 1'b0;
      v10_q <= 1'b0; v11_q <= 1'b0; v12_q <= 1'b0; v13_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v9_q <= v8;
      v10_q <= v9_q;
      v11_q <= v10in;
      v12_q <= v11_q;
      v13_q <= v12;
      done_q <= v13_q;
    end
  end

  // stage 1: differences and degenerate detect
  always_ff @(posedge clk_i) begin
    d1x_q <= {pos_a_x_i[31], pos_a_x_i} - {pos_b_x_i[31], pos_b_x_i};
    d1y_q <= {pos_a_y_i[31], pos_a_y_i} - {pos_b_y_i[31], pos_b_y_i};
    w1x_q <= {vel_a_x_i[31], vel_a_x_i} - {vel_b_x_i[31], vel_b_x_i};
    w1y_q <= {vel_a_y_i[31], vel_a_y_i} - {vel_b_y_i[31], vel_b_y_i};
    s1_q.vax <= vel_a_x_i;
    s1_q.vay <= vel_a_y_i;
    s1_q.vbx <= vel_b_x_i;
    s1_q.vby <= vel_b_y_i;
    s1_q.ma  <= mass_a_i;
    s1_q.mb  <= mass_b_i;
    s1_q.deg <= (pos_a_x_i == pos_b_x_i && pos_a_y_i == pos_b_y_i) ||
                (mass_a_i == 32'd0 && mass_b_i == 32'd0);
    s1_q.nx  <= 1'b0;
    s1_q.ny  <= 1'b0;
  end

  // stage 2: squares and dot-product terms
  assign abx = d1x_q[32] ? -d1x_q : d1x_q;
  assign aby = d1y_q[32] ? -d1y_q : d1y_q;

  always_comb begin
    s2_d    = s1_q;
    s2_d.nx = d1x_q[32];
    s2_d.ny = d1y_q[32];
  end

  always_ff @(posedge clk_i) begin
    sq2x_q <= d1x_q * d1x_q;
    sq2y_q <= d1y_q * d1y_q;
    pw2x_q <= w1x_q * d1x_q;
    pw2y_q <= w1y_q * d1y_q;
    ad2x_q <= abx[31:0];
    ad2y_q <= aby[31:0];
    s2_q   <= s2_d;
  end

  // stage 3: sums
  always_ff @(posedge clk_i) begin
    dd3_q  <= $unsigned(sq2x_q) + $unsigned(sq2y_q);
    p3_q   <= {pw2x_q[65], pw2x_q} + {pw2y_q[65], pw2y_q};
    ad3x_q <= ad2x_q;
    ad3y_q <= ad2y_q;
    s3_q   <= s2_q;
  end

  // stage 4: magnitude of the projection, axis signs
  assign pneg_val = p3_q[66] ? -p3_q : p3_q;

  always_comb begin
    s4_d    = s3_q;
    s4_d.nx = s3_q.nx ^ p3_q[66];
    s4_d.ny = s3_q.ny ^ p3_q[66];
  end

  always_ff @(posedge clk_i) begin
    dd4_q   <= dd3_q;
    pm4_q   <= pneg_val[PMW-1:0];
    ad4x_q  <= ad3x_q;
    ad4y_q  <= ad3y_q;
    s4_q    <= s4_d;
  end

  // stage 5: partial products of |p| * |d|
  always_ff @(posedge clk_i) begin
    dd5_q  <= dd4_q;
    pl5x_q <= pm4_q[33:0] * ad4x_q;
    ph5x_q <= pm4_q[65:34] * ad4x_q;
    pl5y_q <= pm4_q[33:0] * ad4y_q;
    ph5y_q <= pm4_q[65:34] * ad4y_q;
    s5_q   <= s4_q;
  end

  // stage 6
  always_ff @(posedge clk_i) begin
    dd6_q  <= dd5_q;
    pr6x_q <= PRW'(pl5x_q) + (PRW'(ph5x_q) << 34);
    pr6y_q <= PRW'(pl5y_q) + (PRW'(ph5y_q) << 34);
    s6_q   <= s5_q;
  end

  // stage 7: scaled numerator plus half the divisor for rounding
  always_ff @(posedge clk_i) begin
    n7x_q <= {pr6x_q, 16'd0} + {{(NW-DDW+1){1'b0}}, dd6_q[DDW-1:1]};
    n7y_q <= {pr6y_q, 16'd0} + {{(NW-DDW+1){1'b0}}, dd6_q[DDW-1:1]};
    dd7_q <= dd6_q;
    s7_q  <= s6_q;
  end

  ec2d_div u_div_qx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v7_q),
    .num_i  (n7x_q),
    .den_i  (dd7_q),
    .vld_o  (v8),
    .quo_o  (q8x)
  );

  ec2d_div u_div_qy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v7_q),
    .num_i  (n7y_q),
    .den_i  (dd7_q),
    .vld_o  (),
    .quo_o  (q8y)
  );

  always_ff @(posedge clk_i) begin
    sd1_q[0] <= s7_q;
    for (int k = 1; k < QW; k++) begin
      sd1_q[k] <= sd1_q[k-1];
    end
  end

  // stage 9: q * 2m split in two halves
  assign m2a = {sd1_q[QW-1].ma, 1'b0};
  assign m2b = {sd1_q[QW-1].mb, 1'b0};

  always_ff @(posedge clk_i) begin
    al9x_q <= q8x[24:0] * m2b;
    ah9x_q <= q8x[49:25] * m2b;
    al9y_q <= q8y[24:0] * m2b;
    ah9y_q <= q8y[49:25] * m2b;
    bl9x_q <= q8x[24:0] * m2a;
    bh9x_q <= q8x[49:25] * m2a;
    bl9y_q <= q8y[24:0] * m2a;
    bh9y_q <= q8y[49:25] * m2a;
    m9_q   <= {1'b0, sd1_q[QW-1].ma} + {1'b0, sd1_q[QW-1].mb};
    s9_q   <= sd1_q[QW-1];
  end

  // stage 10: numerators for the mass ratio
  assign mround = {{(NW-48){1'b0}}, m9_q, 15'd0};

  always_ff @(posedge clk_i) begin
    na10x_q <= NW'(al9x_q) + (NW'(ah9x_q) << 25) + mround;
    na10y_q <= NW'(al9y_q) + (NW'(ah9y_q) << 25) + mround;
    nb10x_q <= NW'(bl9x_q) + (NW'(bh9x_q) << 25) + mround;
    nb10y_q <= NW'(bl9y_q) + (NW'(bh9y_q) << 25) + mround;
    den10_q <= {{(DW-49){1'b0}}, m9_q, 16'd0};
    s10_q   <= s9_q;
  end

  ec2d_div u_div_dax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v10_q),
    .num_i  (na10x_q),
    .den_i  (den10_q),
    .vld_o  (v10in),
    .quo_o  (dax)
  );

  ec2d_div u_div_day (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v10_q),
    .num_i  (na10y_q),
    .den_i  (den10_q),
    .vld_o  (),
    .quo_o  (day)
  );

  ec2d_div u_div_dbx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v10_q),
    .num_i  (nb10x_q),
    .den_i  (den10_q),
    .vld_o  (),
    .quo_o  (dbx)
  );

  ec2d_div u_div_dby (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v10_q),
    .num_i  (nb10y_q),
    .den_i  (den10_q),
    .vld_o  (),
    .quo_o  (dby)
  );

  always_ff @(posedge clk_i) begin
    sd2_q[0] <= s10_q;
    for (int k = 1; k < QW; k++) begin
      sd2_q[k] <= sd2_q[k-1];
    end
  end

  // stage 11: apply the changes, saturate; side now carries the result velocities
  always_comb begin
    nvax = sd2_q[QW-1].nx
         ? {{6{sd2_q[QW-1].vax[31]}}, sd2_q[QW-1].vax} + {2'b00, dax[VDW-1:0]}
         : {{6{sd2_q[QW-1].vax[31]}}, sd2_q[QW-1].vax} - {2'b00, dax[VDW-1:0]};
    nvay = sd2_q[QW-1].ny
         ? {{6{sd2_q[QW-1].vay[31]}}, sd2_q[QW-1].vay} + {2'b00, day[VDW-1:0]}
         : {{6{sd2_q[QW-1].vay[31]}}, sd2_q[QW-1].vay} - {2'b00, day[VDW-1:0]};
    nvbx = sd2_q[QW-1].nx
         ? {{6{sd2_q[QW-1].vbx[31]}}, sd2_q[QW-1].vbx} - {2'b00, dbx[VDW-1:0]}
         : {{6{sd2_q[QW-1].vbx[31]}}, sd2_q[QW-1].vbx} + {2'b00, dbx[VDW-1:0]};
    nvby = sd2_q[QW-1].ny
         ? {{6{sd2_q[QW-1].vby[31]}}, sd2_q[QW-1].vby} - {2'b00, dby[VDW-1:0]}
         : {{6{sd2_q[QW-1].vby[31]}}, sd2_q[QW-1].vby} + {2'b00, dby[VDW-1:0]};
  end

  always_comb begin
    s11_d = sd2_q[QW-1];
    if (!sd2_q[QW-1].deg) begin
      s11_d.vax = ec2d_pkg::sat32(nvax);
      s11_d.vay = ec2d_pkg::sat32(nvay);
      s11_d.vbx = ec2d_pkg::sat32(nvbx);
      s11_d.vby = ec2d_pkg::sat32(nvby);
    end
  end

  always_ff @(posedge clk_i) begin
    sq11x_q <= dbx[VDW-1:0] * dbx[VDW-1:0];
    sq11y_q <= dby[VDW-1:0] * dby[VDW-1:0];
    s11_q   <= s11_d;
  end

  // stage 12
  always_ff @(posedge clk_i) begin
    s12_q    <= sq11x_q + sq11y_q;
    side12_q <= s11_q;
  end

  ec2d_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v12_q),
    .rad_i  (s12_q),
    .vld_o  (v12),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    sd3_q[0] <= side12_q;
    for (int k = 1; k < RW; k++) begin
      sd3_q[k] <= sd3_q[k-1];
    end
  end

  // stage 13
  always_ff @(posedge clk_i) begin
    pr13_q <= root * sd3_q[RW-1].mb;
    s13_q  <= sd3_q[RW-1];
  end

  // output register: round, drop the fraction, saturate; zero impulse when degenerate
  assign imp_sum = pr13_q + 68'd32768;
  assign imp_w   = imp_sum[67:16];

  always_ff @(posedge clk_i) begin
    nvax_q <= s13_q.vax;
    nvay_q <= s13_q.vay;
    nvbx_q <= s13_q.vbx;
    nvby_q <= s13_q.vby;
    deg_q  <= s13_q.deg;
    if (s13_q.deg) begin
      imp_q <= 32'd0;
    end else if (|imp_w[51:32]) begin
      imp_q <= 32'hffff_ffff;
    end else begin
      imp_q <= imp_w[31:0];
    end
  end

  assign done_o         = done_q;
  assign new_vel_a_x_o  = nvax_q;
  assign new_vel_a_y_o  = nvay_q;
  assign new_vel_b_x_o  = nvbx_q;
  assign new_vel_b_y_o  = nvby_q;
  assign impulse_size_o = imp_q;
  assign degenerate_o   = deg_q;

endmodule
